[rtl/core/touch_long_press_detector_top_macros.svh]
// Assertion macros shared by the touch long press detector RTL.
`ifndef TOUCH_LONG_PRESS_DETECTOR_TOP_MACROS_SVH
`define TOUCH_LONG_PRESS_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tlpd_pkg.sv]
// Constants, register map and helpers for the touch long press detector.
package tlpd_pkg;

	localparam int unsigned MAX_DEVICES = 8;

	localparam logic [4:0] EVT_KEY = 5'd1;
	localparam logic [4:0] EVT_ABS = 5'd3;

	localparam logic [9:0] CODE_ABS_X     = 10'd0;
	localparam logic [9:0] CODE_ABS_Y     = 10'd1;
	localparam logic [9:0] CODE_MT_X      = 10'd53;
	localparam logic [9:0] CODE_MT_Y      = 10'd54;
	localparam logic [9:0] CODE_BTN_TOUCH = 10'd330;

	localparam logic signed [15:0] TOUCH_DOWN = 16'sd1;

	localparam logic [15:0] LONG_CLICK_RESET = 16'd1000;
	localparam logic [15:0] MOVE_FUZZ_RESET  = 16'd30;
	localparam logic [7:0]  ARM_DELAY_RESET  = 8'd20;
	localparam logic signed [15:0] POS_RESET = -16'sd1;

	localparam int unsigned PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_LONG_CLICK = 2'd0,
		REG_MOVE_FUZZ  = 2'd1,
		REG_ARM_DELAY  = 2'd2
	} reg_idx_t;

	// Magnitude of the difference of two signed 16-bit positions.
	function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [16:0] d;
		d = $signed({a[15], a}) - $signed({b[15], b});
		return d[16] ? 17'(-d) : 17'(d);
	endfunction

endpackage

[rtl/core/touch_long_press_detector_top.sv]
// A request passes from the input register to the result register, and waits there for result_ready.
// Throughput: one request per cycle unless stalled; all state updates fit between the two registers.
// A stalled result holds the input register; one more request can wait there, then item_ready drops.
// Reset (arst_n low, asynchronous) restores the register defaults, clears the lock and
// countdown, sets the time to zero and the positions to minus one.
`include "touch_long_press_detector_top_macros.svh"

module touch_long_press_detector_top
	import tlpd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic                      action,
	input  logic [2:0]                device,
	input  logic [4:0]                event_type,
	input  logic [9:0]                event_code,
	input  logic signed [15:0]        event_value,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic                      right_click,
	output logic                      countdown_armed,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic [15:0] long_click_q;
	logic [15:0] move_fuzz_q;
	logic [7:0]  arm_delay_q;

	logic                valid_s1;
	logic                action_s1;
	logic [2:0]          device_s1;
	logic [4:0]          type_s1;
	logic [9:0]          code_s1;
	logic signed [15:0]  value_s1;

	logic [31:0]         now_q;
	logic [31:0]         press_start_q;
	logic signed [15:0]  cur_x_q;
	logic signed [15:0]  cur_y_q;
	logic signed [15:0]  press_x_q;
	logic signed [15:0]  press_y_q;
	logic                lock_valid_q;
	logic [2:0]          lock_device_q;
	logic [7:0]          countdown_q;

	logic                out_valid_q;
	logic                right_click_q;
	logic                armed_q;

	logic                advance;
	logic                cfg_write;
	reg_idx_t            reg_idx;

	logic [31:0]         now_d;
	logic [31:0]         press_start_d;
	logic signed [15:0]  cur_x_d;
	logic signed [15:0]  cur_y_d;
	logic signed [15:0]  press_x_d;
	logic signed [15:0]  press_y_d;
	logic                lock_valid_d;
	logic [2:0]          lock_device_d;
	logic [7:0]          countdown_d;
	logic                fire_d;

	logic                event_ok;
	logic [31:0]         held;
	logic                still;

	assign advance      = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = out_valid_q;
	assign right_click  = right_click_q;
	assign countdown_armed = armed_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_click_q <= LONG_CLICK_RESET;
			move_fuzz_q  <= MOVE_FUZZ_RESET;
			arm_delay_q  <= ARM_DELAY_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_LONG_CLICK: long_click_q <= pwdata[15:0];
				REG_MOVE_FUZZ:  move_fuzz_q  <= pwdata[15:0];
				REG_ARM_DELAY:  arm_delay_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LONG_CLICK: prdata = {16'd0, long_click_q};
			REG_MOVE_FUZZ:  prdata = {16'd0, move_fuzz_q};
			REG_ARM_DELAY:  prdata = {24'd0, arm_delay_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			action_s1 <= action;
			device_s1 <= device;
			type_s1   <= event_type;
			code_s1   <= event_code;
			value_s1  <= event_value;
		end
	end

	assign held  = now_q - press_start_q;
	assign still = (abs_diff(cur_x_q, press_x_q) <= {1'b0, move_fuzz_q}) &&
		(abs_diff(cur_y_q, press_y_q) <= {1'b0, move_fuzz_q});
	assign event_ok = (32'(device_s1) < 32'(MAX_DEVICES)) &&
		!(lock_valid_q && device_s1 != lock_device_q);

	always_comb begin
		now_d         = now_q;
		press_start_d = press_start_q;
		cur_x_d       = cur_x_q;
		cur_y_d       = cur_y_q;
		press_x_d     = press_x_q;
		press_y_d     = press_y_q;
		lock_valid_d  = lock_valid_q;
		lock_device_d = lock_device_q;
		countdown_d   = countdown_q;
		fire_d        = 1'b0;
		if (action_s1) begin
			now_d = now_q + 32'd1;
			if (countdown_q != 8'd0) begin
				countdown_d = countdown_q - 8'd1;
				if (countdown_q == 8'd1) begin
					fire_d       = 1'b1;
					lock_valid_d = 1'b0;
				end
			end
		end else if (event_ok) begin
			if (type_s1 == EVT_ABS) begin
				if (code_s1 == CODE_ABS_X || code_s1 == CODE_MT_X) begin
					cur_x_d = value_s1;
				end else if (code_s1 == CODE_ABS_Y || code_s1 == CODE_MT_Y) begin
					cur_y_d = value_s1;
				end
			end else if (type_s1 == EVT_KEY && code_s1 == CODE_BTN_TOUCH) begin
				if (value_s1 == TOUCH_DOWN) begin
					press_start_d = now_q;
					press_x_d     = cur_x_q;
					press_y_d     = cur_y_q;
					lock_valid_d  = 1'b1;
					lock_device_d = device_s1;
				end else if (held >= {16'd0, long_click_q} && still) begin
					// A zero delay leaves the countdown disarmed.
					countdown_d = arm_delay_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= 32'd0;
			press_start_q <= 32'd0;
			cur_x_q       <= POS_RESET;
			cur_y_q       <= POS_RESET;
			press_x_q     <= POS_RESET;
			press_y_q     <= POS_RESET;
			lock_valid_q  <= 1'b0;
			lock_device_q <= 3'd0;
			countdown_q   <= 8'd0;
		end else if (advance) begin
			now_q         <= now_d;
			press_start_q <= press_start_d;
			cur_x_q       <= cur_x_d;
			cur_y_q       <= cur_y_d;
			press_x_q     <= press_x_d;
			press_y_q     <= press_y_d;
			lock_valid_q  <= lock_valid_d;
			lock_device_q <= lock_device_d;
			countdown_q   <= countdown_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			right_click_q <= fire_d;
			armed_q       <= (countdown_d != 8'd0);
		end
	end

	`TLPD_ASSERT_NOW(a_click_disarms, out_valid_q && right_click_q, !armed_q,
		"right click reported while the countdown is still armed")
	`TLPD_ASSERT_NOW(a_click_unlocks, out_valid_q && right_click_q, !lock_valid_q,
		"device lock still held after a right click")
	`TLPD_ASSERT_NEXT(a_armed_matches, advance, armed_q == (countdown_q != 8'd0),
		"armed flag disagrees with the countdown register")

endmodule
